FILE: design/sarc_pkg.sv
// Shared constants and word types for the set-associative read cache.
`timescale 1ns / 1ps

package sarc_pkg;

   localparam int BLOCK_WORDS = 4;
   localparam int WAYS        = 2;
   localparam int SETS        = 16;
   localparam int STORE_WORDS = 4096;

   localparam int ADDR_W   = 14;
   localparam int DATA_W   = 32;
   localparam int WORD_W   = ADDR_W - 2;
   localparam int OFF_W    = $clog2(BLOCK_WORDS);
   localparam int TAG_W    = WORD_W - OFF_W;
   localparam int SET_W    = $clog2(SETS);
   localparam int WAY_W    = $clog2(WAYS);
   localparam int LINES    = SETS * WAYS;
   localparam int FILL_W   = $clog2(WAYS + 1);
   localparam int CNT_W    = $clog2(BLOCK_WORDS + 1);
   localparam int STORE_AW = $clog2(STORE_WORDS);

   localparam logic ACTION_STORE = 1'b0;
   localparam logic ACTION_READ  = 1'b1;

   typedef struct packed {
      logic              action;
      logic [ADDR_W-1:0] byte_address;
      logic [DATA_W-1:0] write_data;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] ack_address;
      logic [DATA_W-1:0] read_data;
      logic              was_hit;
      logic              evicted;
   } rsp_type;

   // Outcome of a directory lookup; way is the hit way or, on a miss, the victim.
   typedef struct packed {
      logic             hit;
      logic             evict;
      logic [WAY_W-1:0] way;
   } dir_result_type;

endpackage

FILE: design/sarc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module sarc_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: design/sarc_dir.sv
// Cache directory: tag RAM, line valid bits and per-set FIFO replacement state.
`timescale 1ns / 1ps

module sarc_dir
   import sarc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 lookup_en,
   input  logic [SET_W-1:0]     lookup_set,
   input  logic [TAG_W-1:0]     lookup_tag,
   input  logic                 alloc_en,
   output dir_result_type       result
);

   logic [SET_W-1:0]       set_ff;
   logic [TAG_W-1:0]       tag_ff;
   logic [WAYS-1:0]        valid_ff [SETS];
   logic [FILL_W-1:0]      fill_ff [SETS];
   logic [WAY_W-1:0]       oldest_ff [SETS];
   logic [WAYS*TAG_W-1:0]  tag_row;
   logic [WAYS*TAG_W-1:0]  new_row;
   logic                   hit;
   logic [WAY_W-1:0]       hit_way;
   logic                   full;
   logic [WAY_W-1:0]       victim;

   // One row holds the tags of every way of a set.
   sarc_ram #(
      .DEPTH(SETS),
      .WIDTH(WAYS * TAG_W)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (alloc_en),
      .wr_addr (set_ff),
      .wr_data (new_row),
      .rd_en   (lookup_en),
      .rd_addr (lookup_set),
      .rd_data (tag_row)
   );

   always_ff @(posedge clock) begin
      if (lookup_en) begin
         set_ff <= lookup_set;
         tag_ff <= lookup_tag;
      end
   end

   always_comb begin
      hit     = 1'b0;
      hit_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (!hit && valid_ff[set_ff][w] && tag_row[w*TAG_W +: TAG_W] == tag_ff) begin
            hit     = 1'b1;
            hit_way = WAY_W'(w);
         end
      end
      full   = (fill_ff[set_ff] == FILL_W'(WAYS));
      victim = full ? oldest_ff[set_ff] : WAY_W'(fill_ff[set_ff]);
      new_row = tag_row;
      new_row[victim*TAG_W +: TAG_W] = tag_ff;
      result.hit   = hit;
      result.evict = !hit && full;
      result.way   = hit ? hit_way : victim;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SETS; s++) begin
            valid_ff[s]  <= '0;
            fill_ff[s]   <= '0;
            oldest_ff[s] <= '0;
         end
      end else if (alloc_en) begin
         valid_ff[set_ff][victim] <= 1'b1;
         if (full) begin
            oldest_ff[set_ff] <= (victim == WAY_W'(WAYS - 1)) ? '0 : victim + 1'b1;
         end else begin
            fill_ff[set_ff] <= fill_ff[set_ff] + 1'b1;
         end
      end
   end

endmodule

FILE: design/set_assoc_read_cache_fifo.sv
// Top level of the set-associative read cache with FIFO replacement.
`timescale 1ns / 1ps

// Read-only set-associative cache in front of a word backing store. After reset the
// block holds busy while it clears the backing store. A store write is written when
// it is accepted and leaves busy low. A read that hits passes the tag RAM read, then
// the line data read, whose word appears on the result ports in the following
// cycle while the next word may already be accepted. On a miss the single read port
// of the backing store copies the block into the line one word per cycle, and the
// result follows the last word. Every read gives exactly one result, held for one
// cycle only, since the receiver cannot stall; a store write gives none. Store
// writes do not update lines already in the cache.
module set_assoc_read_cache_fifo
   import sarc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   output logic    rsp_valid,
   output rsp_type rsp_word
);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_LOOKUP = 2'd2;
   localparam logic [1:0] ST_FILL   = 2'd3;

   localparam int LINE_AW = SET_W + WAY_W + OFF_W;

   logic [1:0]          state_ff, state_in;
   logic [STORE_AW-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   req_type             req_ff;
   logic [WAY_W-1:0]    victim_ff, victim_in;
   logic                oob_ff, oob_in;
   logic [DATA_W-1:0]   fill_word_ff, fill_word_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic                rsp_evict_ff, rsp_evict_in;

   logic                accept;
   logic [WORD_W-1:0]   in_word;
   logic [WORD_W-1:0]   word_q;
   logic [TAG_W-1:0]    block_q;
   logic [OFF_W-1:0]    off_q;
   logic [SET_W-1:0]    set_q;
   logic [CNT_W-1:0]    cnt_prev;
   logic [WORD_W-1:0]   fill_word_addr;
   dir_result_type      dir_res;
   logic                alloc_en;

   logic                store_we;
   logic [STORE_AW-1:0] store_waddr;
   logic [DATA_W-1:0]   store_wdata;
   logic                store_re;
   logic [DATA_W-1:0]   store_q;
   logic                line_we;
   logic [LINE_AW-1:0]  line_waddr;
   logic [DATA_W-1:0]   line_wdata;
   logic                line_re;
   logic [LINE_AW-1:0]  line_raddr;
   logic [DATA_W-1:0]   line_q;

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign in_word = req_word.byte_address[ADDR_W-1:2];
   assign word_q  = req_ff.byte_address[ADDR_W-1:2];
   assign block_q = word_q[WORD_W-1:OFF_W];
   assign off_q   = word_q[OFF_W-1:0];
   assign set_q   = block_q[SET_W-1:0];
   assign cnt_prev       = cnt_ff - 1'b1;
   assign fill_word_addr = {block_q, cnt_ff[OFF_W-1:0]};

   // Backing store writes come from the clearing pass or from an accepted store word.
   always_comb begin
      store_we    = 1'b0;
      store_waddr = clr_ff;
      store_wdata = '0;
      if (state_ff == ST_CLEAR) begin
         store_we = 1'b1;
      end else if (accept && req_word.action == ACTION_STORE) begin
         store_we    = (32'(in_word) < 32'(STORE_WORDS));
         store_waddr = STORE_AW'(in_word);
         store_wdata = req_word.write_data;
      end
   end

   assign store_re = (state_ff == ST_FILL) && (cnt_ff < CNT_W'(BLOCK_WORDS));

   sarc_ram #(
      .DEPTH(STORE_WORDS),
      .WIDTH(DATA_W)
   ) u_store_ram (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (store_waddr),
      .wr_data (store_wdata),
      .rd_en   (store_re),
      .rd_addr (STORE_AW'(fill_word_addr)),
      .rd_data (store_q)
   );

   sarc_dir u_dir (
      .clock      (clock),
      .reset      (reset),
      .lookup_en  (accept && req_word.action == ACTION_READ),
      .lookup_set (in_word[OFF_W +: SET_W]),
      .lookup_tag (in_word[WORD_W-1:OFF_W]),
      .alloc_en   (alloc_en),
      .result     (dir_res)
   );

   assign alloc_en   = (state_ff == ST_LOOKUP) && !dir_res.hit;
   assign line_re    = (state_ff == ST_LOOKUP) && dir_res.hit;
   assign line_raddr = {set_q, dir_res.way, off_q};
   assign line_we    = (state_ff == ST_FILL) && (cnt_ff != '0);
   assign line_waddr = {set_q, victim_ff, cnt_prev[OFF_W-1:0]};
   assign line_wdata = oob_ff ? '0 : store_q;

   sarc_ram #(
      .DEPTH(LINES * BLOCK_WORDS),
      .WIDTH(DATA_W)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (line_we),
      .wr_addr (line_waddr),
      .wr_data (line_wdata),
      .rd_en   (line_re),
      .rd_addr (line_raddr),
      .rd_data (line_q)
   );

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cnt_in       = cnt_ff;
      victim_in    = victim_ff;
      oob_in       = oob_ff;
      fill_word_in = fill_word_ff;
      rsp_valid_in = 1'b0;
      rsp_hit_in   = rsp_hit_ff;
      rsp_evict_in = rsp_evict_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == STORE_AW'(STORE_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && req_word.action == ACTION_READ) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (dir_res.hit) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b1;
               rsp_evict_in = 1'b0;
            end else begin
               state_in     = ST_FILL;
               victim_in    = dir_res.way;
               rsp_evict_in = dir_res.evict;
               cnt_in       = '0;
            end
         end
         ST_FILL: begin
            // Read word cnt from the store while writing word cnt-1 into the line.
            cnt_in = cnt_ff + 1'b1;
            oob_in = !(32'(fill_word_addr) < 32'(STORE_WORDS));
            if (line_we && cnt_prev[OFF_W-1:0] == off_q) begin
               fill_word_in = line_wdata;
            end
            if (cnt_ff == CNT_W'(BLOCK_WORDS)) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_word;
      end
      cnt_ff       <= cnt_in;
      victim_ff    <= victim_in;
      oob_ff       <= oob_in;
      fill_word_ff <= fill_word_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_evict_ff <= rsp_evict_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_word.ack_address = req_ff.byte_address;
   assign rsp_word.read_data   = rsp_hit_ff ? line_q : fill_word_ff;
   assign rsp_word.was_hit     = rsp_hit_ff;
   assign rsp_word.evicted     = rsp_evict_ff;

`ifndef NO_ASSERTIONS
   // Each read gives a single result word; two in a row would mean a doubled response.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // A result only follows a lookup that hit or a completed block fill.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == ST_LOOKUP || $past(state_ff) == ST_FILL))
      else $error("result without a preceding lookup or fill");

   // The backing store is only written while no fill can be reading it.
   a_store_write_quiet: assert property (@(posedge clock) disable iff (reset)
      store_we |-> (state_ff == ST_CLEAR || state_ff == ST_IDLE))
      else $error("backing store written during a lookup or fill");
`endif

endmodule

FILE: sim/tb_set_assoc_read_cache_fifo.sv
// Self-checking testbench for the set-associative read cache with FIFO replacement.
`timescale 1ns / 1ps

module tb_set_assoc_read_cache_fifo;
   import sarc_pkg::*;

   localparam int RANDOM_WORDS   = 1350;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_EVERY    = 450;
   localparam int SETTLE_CYCLES  = 20;
   localparam int REPORT_MAX     = 10;
   localparam int RESET_CYCLES   = 11;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_word = '0;
   logic    rsp_valid;
   rsp_type rsp_word;

   req_type pending_words[$];
   rsp_type expected_reads[$];

   // Shadow copy of the backing store and the cache directory.
   logic [DATA_W-1:0] store_copy [STORE_WORDS];
   logic              line_ok    [LINES];
   logic [TAG_W-1:0]  line_block [LINES];
   logic [DATA_W-1:0] line_data  [LINES][BLOCK_WORDS];
   int                set_fill   [SETS];
   int                set_head   [SETS];

   int total_words    = 0;
   int sent_words     = 0;
   int store_count    = 0;
   int read_count     = 0;
   int hit_count      = 0;
   int evict_count    = 0;
   int mismatch_count = 0;
   int stall_cycles   = 0;

   set_assoc_read_cache_fifo u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Looks up one read in the shadow cache, filling or replacing a line on a miss.
   function automatic rsp_type cache_lookup(req_type w);
      logic [WORD_W-1:0] word_idx;
      logic [TAG_W-1:0]  blk;
      logic [OFF_W-1:0]  off;
      logic [SET_W-1:0]  set_idx;
      int                base;
      int                line;
      int                victim;
      rsp_type           r;
      word_idx      = w.byte_address[ADDR_W-1:2];
      blk           = word_idx[WORD_W-1:OFF_W];
      off           = word_idx[OFF_W-1:0];
      set_idx       = blk[SET_W-1:0];
      base          = set_idx * WAYS;
      r             = '0;
      r.ack_address = w.byte_address;
      line          = -1;
      for (int way = 0; way < WAYS; way++) begin
         if (line < 0 && line_ok[base + way] && line_block[base + way] == blk) begin
            line = base + way;
         end
      end
      if (line >= 0) begin
         r.was_hit = 1'b1;
      end else begin
         if (set_fill[set_idx] >= WAYS) begin
            victim            = set_head[set_idx];
            set_head[set_idx] = (victim + 1) % WAYS;
            r.evicted         = 1'b1;
         end else begin
            victim            = set_fill[set_idx];
            set_fill[set_idx] = set_fill[set_idx] + 1;
         end
         line             = base + victim;
         line_ok[line]    = 1'b1;
         line_block[line] = blk;
         for (int i = 0; i < BLOCK_WORDS; i++) begin
            line_data[line][i] = store_copy[blk * BLOCK_WORDS + i];
         end
      end
      r.read_data = line_data[line][off];
      return r;
   endfunction

   task automatic queue_word(input logic act, input int addr, input logic [DATA_W-1:0] data);
      req_type w;
      w.action       = act;
      w.byte_address = addr[ADDR_W-1:0];
      w.write_data   = data;
      pending_words.push_back(w);
   endtask

   // Driver: offers the next word unless idling or waiting for the cache to drain.
   always @(posedge clock) begin : driver
      int idle_pct;
      bit hold;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            sent_words++;
            if (req_word.action == ACTION_READ) begin
               expected_reads.push_back(cache_lookup(req_word));
            end else begin
               store_copy[req_word.byte_address[ADDR_W-1:2]] = req_word.write_data;
               store_count++;
            end
         end
         if (!start || !busy) begin
            if (sent_words < total_words / 3) begin
               idle_pct = 8;
            end else if (sent_words < 2 * total_words / 3) begin
               idle_pct = 72;
            end else begin
               idle_pct = 0;
            end
            hold = ($urandom_range(99, 0) < idle_pct);
            if (sent_words != 0 && sent_words % DRAIN_EVERY == 0
                && expected_reads.size() != 0) begin
               hold = 1'b1;
            end
            if (pending_words.size() != 0 && !hold) begin
               start    <= 1'b1;
               req_word <= pending_words.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobed result must match the oldest outstanding read.
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_reads.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX) begin
               $display("Unexpected result: addr %h data %h hit %0d evict %0d",
                        rsp_word.ack_address, rsp_word.read_data,
                        rsp_word.was_hit, rsp_word.evicted);
            end
         end else begin
            want = expected_reads.pop_front();
            read_count++;
            hit_count   += want.was_hit;
            evict_count += want.evicted;
            if (rsp_word.ack_address !== want.ack_address
                || rsp_word.read_data !== want.read_data
                || rsp_word.was_hit !== want.was_hit
                || rsp_word.evicted !== want.evicted) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX) begin
                  $display("Mismatch: expected addr %h data %h hit %0d evict %0d",
                           want.ack_address, want.read_data, want.was_hit, want.evicted);
                  $display("          actual   addr %h data %h hit %0d evict %0d",
                           rsp_word.ack_address, rsp_word.read_data,
                           rsp_word.was_hit, rsp_word.evicted);
               end
            end
         end
      end
   end

   // The clearing pass after reset keeps busy high, which the watchdog counts as a stall.
   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired after %0d cycles without progress.", stall_cycles);
         $display("set_assoc_read_cache_fifo regression: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      int tag;
      int addr;
      logic              act;
      logic [DATA_W-1:0] data;
      foreach (store_copy[i]) store_copy[i] = '0;
      foreach (line_ok[i]) line_ok[i] = 1'b0;
      foreach (set_fill[i]) begin
         set_fill[i] = 0;
         set_head[i] = 0;
      end

      queue_word(ACTION_STORE, 'h0000, 32'hFFFF_FFFF);
      queue_word(ACTION_STORE, 'h0007, 32'hA5A5_5A5A);
      queue_word(ACTION_STORE, 'h3FFF, 32'hFFFF_FFFF);
      queue_word(ACTION_READ,  'h0000, 32'h0000_0000);
      queue_word(ACTION_READ,  'h0005, 32'hFFFF_FFFF);
      queue_word(ACTION_READ,  'h000E, 32'h0000_0000);
      // The cached copy must stay stale after a store write to the same word.
      queue_word(ACTION_STORE, 'h0000, 32'h1234_5678);
      queue_word(ACTION_READ,  'h0003, 32'h0000_0000);
      queue_word(ACTION_READ,  'h0100, 32'h0000_0000);
      queue_word(ACTION_READ,  'h0200, 32'h0000_0000);
      queue_word(ACTION_READ,  'h0000, 32'h0000_0000);
      queue_word(ACTION_READ,  'h0104, 32'h0000_0000);
      queue_word(ACTION_READ,  'h3FFC, 32'h0000_0000);
      queue_word(ACTION_READ,  'h3FFF, 32'h0000_0000);
      queue_word(ACTION_READ,  'h3EF0, 32'h0000_0000);
      queue_word(ACTION_READ,  'h3DF0, 32'h0000_0000);
      queue_word(ACTION_READ,  'h3FF0, 32'h0000_0000);
      queue_word(ACTION_STORE, 'h2AAA, 32'h5555_AAAA);
      queue_word(ACTION_READ,  'h2AA9, 32'hFFFF_FFFF);
      queue_word(ACTION_READ,  'h2AA4, 32'h0000_0000);
      queue_word(ACTION_READ,  'h0200, 32'h0000_0000);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         act = ($urandom_range(99, 0) < 70) ? ACTION_READ : ACTION_STORE;
         if ($urandom_range(99, 0) < 65) begin
            // A few hot blocks per set keep hits and FIFO evictions frequent.
            tag = $urandom_range(3, 0);
            if (tag == 3) tag = 63;
            addr = (tag << 8) | $urandom_range(255, 0);
         end else begin
            addr = $urandom_range(16383, 0);
         end
         case ($urandom_range(9, 0))
            0:       data = '0;
            1:       data = '1;
            default: data = $urandom();
         endcase
         queue_word(act, addr, data);
      end
      total_words = pending_words.size();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (sent_words != total_words) @(posedge clock);
      while (expected_reads.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d words: %0d store writes and %0d reads checked.",
               sent_words, store_count, read_count);
      $display("Reads gave %0d hits and %0d misses, %0d of them replacing a line.",
               hit_count, read_count - hit_count, evict_count);
      if (mismatch_count == 0) begin
         $display("set_assoc_read_cache_fifo regression: pass");
      end else begin
         $display("%0d mismatches.", mismatch_count);
         $display("set_assoc_read_cache_fifo regression: fail");
      end
      $finish;
   end

endmodule

FILE: set_assoc_read_cache_fifo.f
design/sarc_pkg.sv
design/sarc_ram.sv
design/sarc_dir.sv
design/set_assoc_read_cache_fifo.sv
sim/tb_set_assoc_read_cache_fifo.sv
